// File: src/tilt_compensated_heading_macros.svh
// ----------------------------------------------------------------------------
// tilt compensated heading assertion macros
// concurrent property checks, empty when synthesised
// ----------------------------------------------------------------------------
`ifndef TILT_COMPENSATED_HEADING_MACROS_SVH
`define TILT_COMPENSATED_HEADING_MACROS_SVH

`ifndef SYNTHESIS
`define TCH_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define TCH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TCH_ASSERT_IMPL(lbl, ante, cons, msg)
`define TCH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: src/tch_pkg.sv
// ----------------------------------------------------------------------------
// tch_pkg
// types, constants and tables for the tilt compensated heading pipeline
// ----------------------------------------------------------------------------
package tch_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int NSTG          = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
  localparam int SQRT_STEPS    = 16;

  // vectoring datapath, angle accumulator, rotation datapath
  localparam int VW = 36;
  localparam int AW = 28;
  localparam int RW = 34;

  localparam logic signed [AW-1:0] DEG90    = AW'(90 * 65536);
  localparam logic signed [AW-1:0] DEG180   = AW'(180 * 65536);
  localparam logic signed [RW-1:0] KINV_Q30 = RW'(652032874);
  localparam logic signed [AW-1:0] HALF_LSB = AW'(512);

  localparam logic signed [17:0] ROLL_LIM    = 18'sd11520;
  localparam logic signed [17:0] PITCH_LIM   = 18'sd5760;
  localparam logic signed [17:0] FULL_TURN   = 18'sd23040;
  localparam logic [14:0]        HEADING_TOP = 15'd23040;

  typedef enum logic [1:0] {
    SRC_NONE         = 2'd0,
    SRC_ACC_GYRO     = 2'd1,
    SRC_ACC_GYRO_MAG = 2'd2
  } source_e;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_ZERO = 2'd3
  } axis_e;

  typedef enum logic [2:0] {
    REG_ENABLE = 3'd0,
    REG_X_SRC  = 3'd1,
    REG_Y_SRC  = 3'd2,
    REG_Z_SRC  = 3'd3,
    REG_X_NEG  = 3'd4,
    REG_Y_NEG  = 3'd5,
    REG_Z_NEG  = 3'd6
  } reg_e;

  typedef struct packed {
    logic             att_ok;
    source_e          src;
    logic signed [15:0] gyro;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [16:0] bx;
    logic signed [16:0] by;
    logic signed [16:0] bz;
  } ctx_t;

  typedef struct packed {
    logic               zero;
    logic signed [AW-1:0] ang;
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
  } vec_t;

  typedef struct packed {
    logic               neg;
    logic signed [AW-1:0] z;
    logic signed [RW-1:0] x;
    logic signed [RW-1:0] y;
  } rot_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic signed [AW-1:0] atan_lut(int idx);
    logic signed [AW-1:0] v;
    unique case (idx)
      0:       v = AW'(2949120);
      1:       v = AW'(1740967);
      2:       v = AW'(919879);
      3:       v = AW'(466945);
      4:       v = AW'(234379);
      5:       v = AW'(117304);
      6:       v = AW'(58666);
      7:       v = AW'(29335);
      8:       v = AW'(14668);
      9:       v = AW'(7334);
      10:      v = AW'(3667);
      11:      v = AW'(1833);
      12:      v = AW'(917);
      13:      v = AW'(458);
      14:      v = AW'(229);
      15:      v = AW'(115);
      16:      v = AW'(57);
      17:      v = AW'(29);
      18:      v = AW'(14);
      19:      v = AW'(7);
      20:      v = AW'(4);
      21:      v = AW'(2);
      22:      v = AW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: src/tilt_compensated_heading.sv
// ----------------------------------------------------------------------------
// tilt_compensated_heading
// roll, pitch and tilt compensated magnetic heading from one imu sample
// ----------------------------------------------------------------------------
// One IMU sample enters per clock and one result leaves per clock once the
// pipeline is full, while the output is not stalled. The datapath is a 16 step
// square root, then three CORDIC chains one stage per iteration (roll and pitch
// vectoring side by side, sin/cos rotation side by side, heading vectoring),
// with two multiplier stages in between. The whole pipeline advances whenever
// the output register is empty or being taken.
`include "tilt_compensated_heading_macros.svh"

module tilt_compensated_heading (
  input  logic          clk_i,
  input  logic          rst_ni,
  // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z, gyro_z
  input  logic [111:0]  s_axis_tdata,
  // imu_enabled, imu_present, mag_present
  input  logic [2:0]    s_axis_tuser,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // roll_angle, pitch_angle, yaw_rate, heading_angle, zero fill
  output logic [63:0]   m_axis_tdata,
  // attitude_valid, sensor_source
  output logic [2:0]    m_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [1:0]    cfg_data_i
);
  import tch_pkg::*;

  localparam int P_SUM = 2;
  localparam int P_VI  = P_SUM + SQRT_STEPS + 1;
  localparam int P_ANG = P_VI + NSTG + 1;
  localparam int P_RI  = P_ANG + 1;
  localparam int P_SC  = P_RI + NSTG + 1;
  localparam int P_MUL = P_SC + 1;
  localparam int P_HS  = P_MUL + 1;
  localparam int P_M2  = P_HS + 1;
  localparam int P_HY  = P_M2 + 1;
  localparam int P_HI  = P_HY + 1;
  localparam int P_OUT = P_HI + NSTG + 1;

  function automatic logic signed [16:0] pick_axis(axis_e s, logic neg,
      logic signed [15:0] mx, logic signed [15:0] my, logic signed [15:0] mz);
    logic signed [16:0] v;
    unique case (s)
      AXIS_X:    v = {mx[15], mx};
      AXIS_Y:    v = {my[15], my};
      AXIS_Z:    v = {mz[15], mz};
      AXIS_ZERO: v = '0;
      default:   v = '0;
    endcase
    return neg ? -v : v;
  endfunction

  function automatic vec_t vec_init(logic signed [VW-1:0] y, logic signed [VW-1:0] x);
    vec_t v;
    v.zero = (x == '0) && (y == '0);
    if (x[VW-1]) begin
      v.ang = y[VW-1] ? -DEG180 : DEG180;
      v.x   = -x;
      v.y   = -y;
    end else begin
      v.ang = '0;
      v.x   = x;
      v.y   = y;
    end
    return v;
  endfunction

  function automatic vec_t vec_step(vec_t v, int sh);
    vec_t n;
    n = v;
    if (!v.y[VW-1]) begin
      n.x   = v.x + (v.y >>> sh);
      n.y   = v.y - (v.x >>> sh);
      n.ang = v.ang + atan_lut(sh);
    end else begin
      n.x   = v.x - (v.y >>> sh);
      n.y   = v.y + (v.x >>> sh);
      n.ang = v.ang - atan_lut(sh);
    end
    return n;
  endfunction

  function automatic rot_t rot_init(logic signed [AW-1:0] z);
    rot_t r;
    r.x = KINV_Q30;
    r.y = '0;
    if (z > DEG90) begin
      r.z   = z - DEG180;
      r.neg = 1'b1;
    end else if (z < -DEG90) begin
      r.z   = z + DEG180;
      r.neg = 1'b1;
    end else begin
      r.z   = z;
      r.neg = 1'b0;
    end
    return r;
  endfunction

  function automatic rot_t rot_step(rot_t v, int sh);
    rot_t n;
    n = v;
    if (!v.z[AW-1]) begin
      n.x = v.x - (v.y >>> sh);
      n.y = v.y + (v.x >>> sh);
      n.z = v.z - atan_lut(sh);
    end else begin
      n.x = v.x + (v.y >>> sh);
      n.y = v.y - (v.x >>> sh);
      n.z = v.z + atan_lut(sh);
    end
    return n;
  endfunction

  // 2^-16 degree to 1/64 degree, rounded
  function automatic logic signed [AW-11:0] to_deg64(vec_t v);
    logic signed [AW-1:0] s;
    s = v.ang + HALF_LSB;
    return v.zero ? '0 : s[AW-1:10];
  endfunction

  function automatic logic signed [17:0] clamp(logic signed [17:0] v,
      logic signed [17:0] lim);
    logic signed [17:0] r;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // configuration registers
  logic  en_q;
  axis_e xsrc_q, ysrc_q, zsrc_q;
  logic  xneg_q, yneg_q, zneg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b1;
      xsrc_q <= AXIS_X;
      ysrc_q <= AXIS_Y;
      zsrc_q <= AXIS_Z;
      xneg_q <= 1'b0;
      yneg_q <= 1'b0;
      zneg_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_ENABLE: en_q   <= cfg_data_i[0];
        REG_X_SRC:  xsrc_q <= axis_e'(cfg_data_i);
        REG_Y_SRC:  ysrc_q <= axis_e'(cfg_data_i);
        REG_Z_SRC:  zsrc_q <= axis_e'(cfg_data_i);
        REG_X_NEG:  xneg_q <= cfg_data_i[0];
        REG_Y_NEG:  yneg_q <= cfg_data_i[0];
        REG_Z_NEG:  zneg_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [P_OUT:0] vld_q;
  logic           adv;

  assign adv           = !vld_q[P_OUT] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[P_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[P_OUT-1:0], s_axis_tvalid};
    end
  end

  // input stage: flags and magnetometer remap
  ctx_t ctx_d;
  ctx_t ctx_q [P_OUT];
  logic compute;

  always_comb begin
    compute       = en_q && s_axis_tuser[0] && s_axis_tuser[1];
    ctx_d.att_ok  = compute && s_axis_tuser[2];
    ctx_d.src     = !compute ? SRC_NONE : (s_axis_tuser[2] ? SRC_ACC_GYRO_MAG : SRC_ACC_GYRO);
    ctx_d.ax      = s_axis_tdata[15:0];
    ctx_d.ay      = s_axis_tdata[31:16];
    ctx_d.az      = s_axis_tdata[47:32];
    ctx_d.gyro    = s_axis_tdata[111:96];
    ctx_d.bx      = pick_axis(xsrc_q, xneg_q, s_axis_tdata[63:48], s_axis_tdata[79:64],
                              s_axis_tdata[95:80]);
    ctx_d.by      = pick_axis(ysrc_q, yneg_q, s_axis_tdata[63:48], s_axis_tdata[79:64],
                              s_axis_tdata[95:80]);
    ctx_d.bz      = pick_axis(zsrc_q, zneg_q, s_axis_tdata[63:48], s_axis_tdata[79:64],
                              s_axis_tdata[95:80]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctx_q[0] <= ctx_d;
    end
  end

  for (genvar p = 1; p < P_OUT; p++) begin : g_ctx
    always_ff @(posedge clk_i) begin
      if (adv) begin
        ctx_q[p] <= ctx_q[p-1];
      end
    end
  end

  // squares and integer square root of ay^2 + az^2
  logic signed [31:0] sqy_q, sqz_q;
  logic [32:0]        sv_q [P_SUM:P_VI-1];
  logic [32:0]        sr_q [P_SUM:P_VI-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqy_q       <= ctx_q[0].ay * ctx_q[0].ay;
      sqz_q       <= ctx_q[0].az * ctx_q[0].az;
      sv_q[P_SUM] <= {1'b0, sqy_q} + {1'b0, sqz_q};
      sr_q[P_SUM] <= '0;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [32:0] BIT = 33'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [32:0] trial;
    assign trial = sr_q[P_SUM+k] + BIT;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (sv_q[P_SUM+k] >= trial) begin
          sv_q[P_SUM+k+1] <= sv_q[P_SUM+k] - trial;
          sr_q[P_SUM+k+1] <= (sr_q[P_SUM+k] >> 1) + BIT;
        end else begin
          sv_q[P_SUM+k+1] <= sv_q[P_SUM+k];
          sr_q[P_SUM+k+1] <= sr_q[P_SUM+k] >> 1;
        end
      end
    end
  end

  // roll and pitch vectoring
  vec_t rv_q [P_VI:P_VI+NSTG];
  vec_t pv_q [P_VI:P_VI+NSTG];
  logic signed [VW-1:0] roll_y, roll_x, pitch_y, pitch_x;

  always_comb begin
    roll_y  = VW'(ctx_q[P_VI-1].ay) <<< 14;
    roll_x  = VW'(ctx_q[P_VI-1].az) <<< 14;
    pitch_y = -(VW'(ctx_q[P_VI-1].ax) <<< 14);
    pitch_x = VW'({1'b0, sr_q[P_VI-1][16:0]}) <<< 14;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rv_q[P_VI] <= vec_init(roll_y, roll_x);
      pv_q[P_VI] <= vec_init(pitch_y, pitch_x);
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_vec_rp
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rv_q[P_VI+i+1] <= vec_step(rv_q[P_VI+i], i);
        pv_q[P_VI+i+1] <= vec_step(pv_q[P_VI+i], i);
      end
    end
  end

  // roll and pitch in 1/64 degree, carried to the output
  logic signed [14:0] roll_q  [P_ANG:P_OUT-1];
  logic signed [13:0] pitch_q [P_ANG:P_OUT-1];
  logic signed [17:0] roll_c, pitch_c;

  always_comb begin
    roll_c  = clamp(to_deg64(rv_q[P_ANG-1]), ROLL_LIM);
    pitch_c = clamp(to_deg64(pv_q[P_ANG-1]), PITCH_LIM);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      roll_q[P_ANG]  <= roll_c[14:0];
      pitch_q[P_ANG] <= pitch_c[13:0];
    end
  end

  for (genvar p = P_ANG + 1; p < P_OUT; p++) begin : g_ang
    always_ff @(posedge clk_i) begin
      if (adv) begin
        roll_q[p]  <= roll_q[p-1];
        pitch_q[p] <= pitch_q[p-1];
      end
    end
  end

  // sin and cos of roll and pitch
  rot_t rr_q [P_RI:P_RI+NSTG];
  rot_t pr_q [P_RI:P_RI+NSTG];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rr_q[P_RI] <= rot_init({{(AW-25){roll_q[P_RI-1][14]}}, roll_q[P_RI-1], 10'b0});
      pr_q[P_RI] <= rot_init({{(AW-24){pitch_q[P_RI-1][13]}}, pitch_q[P_RI-1], 10'b0});
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_rot
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rr_q[P_RI+i+1] <= rot_step(rr_q[P_RI+i], i);
        pr_q[P_RI+i+1] <= rot_step(pr_q[P_RI+i], i);
      end
    end
  end

  logic signed [RW-1:0] sr_sc_q, cr_sc_q, sp_sc_q, cp_sc_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sr_sc_q <= rr_q[P_SC-1].neg ? -rr_q[P_SC-1].y : rr_q[P_SC-1].y;
      cr_sc_q <= rr_q[P_SC-1].neg ? -rr_q[P_SC-1].x : rr_q[P_SC-1].x;
      sp_sc_q <= pr_q[P_SC-1].neg ? -pr_q[P_SC-1].y : pr_q[P_SC-1].y;
      cp_sc_q <= pr_q[P_SC-1].neg ? -pr_q[P_SC-1].x : pr_q[P_SC-1].x;
    end
  end

  // tilt compensation products
  logic signed [RW+16:0] bxcp_q, bzsp_q, bzcp_q, bxsp_q, bycr_q;
  logic signed [RW-1:0]  sr_mul_q;
  logic signed [RW+17:0] hx_sum, w_sum;
  logic signed [VW-1:0]  hx_hs_q, byc_hs_q;
  // w and sin roll both fit 32 bits signed
  logic signed [31:0]    w_hs_q, sr_hs_q;
  logic signed [63:0]    wsr_q;
  logic signed [VW-1:0]  hx_m2_q, byc_m2_q, hx_hy_q, hy_hy_q;

  assign hx_sum = bxcp_q + bzsp_q;
  assign w_sum  = bzcp_q - bxsp_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bxcp_q   <= ctx_q[P_MUL-1].bx * cp_sc_q;
      bzsp_q   <= ctx_q[P_MUL-1].bz * sp_sc_q;
      bzcp_q   <= ctx_q[P_MUL-1].bz * cp_sc_q;
      bxsp_q   <= ctx_q[P_MUL-1].bx * sp_sc_q;
      bycr_q   <= ctx_q[P_MUL-1].by * cr_sc_q;
      sr_mul_q <= sr_sc_q;

      hx_hs_q  <= hx_sum[VW+14:15];
      w_hs_q   <= w_sum[46:15];
      byc_hs_q <= bycr_q[VW+14:15];
      sr_hs_q  <= sr_mul_q[31:0];

      wsr_q    <= w_hs_q * sr_hs_q;
      hx_m2_q  <= hx_hs_q;
      byc_m2_q <= byc_hs_q;

      hx_hy_q  <= hx_m2_q;
      hy_hy_q  <= byc_m2_q - VW'($signed(wsr_q[63:30]));
    end
  end

  // heading vectoring
  vec_t hv_q [P_HI:P_HI+NSTG];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hv_q[P_HI] <= vec_init(hy_hy_q, hx_hy_q);
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_vec_h
    always_ff @(posedge clk_i) begin
      if (adv) begin
        hv_q[P_HI+i+1] <= vec_step(hv_q[P_HI+i], i);
      end
    end
  end

  // output register
  logic signed [17:0] head_raw, head_wrap;
  ctx_t               ctx_last;
  logic [63:0]        tdata_d, tdata_q;
  logic [2:0]         tuser_d, tuser_q;

  always_comb begin
    ctx_last = ctx_q[P_OUT-1];
    head_raw = to_deg64(hv_q[P_OUT-1]);
    if (head_raw[17]) begin
      head_wrap = head_raw + FULL_TURN;
    end else if (head_raw >= FULL_TURN) begin
      head_wrap = head_raw - FULL_TURN;
    end else begin
      head_wrap = head_raw;
    end
    tuser_d = {ctx_last.src, ctx_last.att_ok};
    if (ctx_last.att_ok) begin
      tdata_d = {4'b0, head_wrap[14:0], ctx_last.gyro, pitch_q[P_OUT-1],
                 roll_q[P_OUT-1]};
    end else begin
      tdata_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tdata_q <= tdata_d;
      tuser_q <= tuser_d;
    end
  end

  assign m_axis_tdata = tdata_q;
  assign m_axis_tuser = tuser_q;

  `TCH_ASSERT_IMPL(a_valid_src, m_axis_tvalid && m_axis_tuser[0], m_axis_tuser[2:1] == SRC_ACC_GYRO_MAG, "valid attitude without full source")
  `TCH_ASSERT_IMPL(a_zero_fields, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0, "fields not zeroed when attitude invalid")
  `TCH_ASSERT_IMPL(a_heading_range, m_axis_tvalid, m_axis_tdata[59:45] < HEADING_TOP, "heading out of range")
  `TCH_ASSERT_NEXT(a_stall_hold, !adv, vld_q == $past(vld_q), "pipeline moved while stalled")

endmodule
